// ===== src/lcgr_pkg.sv =====
`timescale 1ns / 1ps

package lcgr_pkg;

    localparam int WORD_W = 32;

    // Generator constants
    localparam logic [WORD_W-1:0] LCG_MUL      = 32'd214013;
    localparam logic [WORD_W-1:0] LCG_ADD      = 32'd2531011;
    localparam int                TEMPER_SHIFT = 15;

    // Operation codes
    typedef enum logic {
        FUNC_SEED = 1'b0,
        FUNC_DRAW = 1'b1
    } func_t;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_STEP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    // Status from the remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== src/lcgr_mod_unit.sv =====
`timescale 1ns / 1ps

module lcgr_mod_unit
    import lcgr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output div_status_t       status,
    output logic [WORD_W-1:0] remainder
);

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] rem_next;
    logic [WORD_W-1:0] dvd_reg;
    logic [WORD_W-1:0] dvd_next;
    logic [WORD_W-1:0] dvs_reg;
    logic [WORD_W-1:0] dvs_next;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   trial;

    // Shift one dividend bit in and try the subtraction
    assign shifted = {rem_reg, dvd_reg[WORD_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WORD_W - 1);
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // Keep the difference unless it borrowed
            rem_next = trial[WORD_W] ? shifted[WORD_W-1:0] : trial[WORD_W-1:0];
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule

// ===== src/lcg_ranged_random_generator_unit.sv =====
`timescale 1ns / 1ps

// Channel  | Signals                                                   | Beat
// ---------+-----------------------------------------------------------+-------------------
// input    | in_valid, in_ready, func, seed_value, system_time,        | one request
//          | use_self, min_value, max_value                            |
// output   | out_valid, out_ready, value                               | one result
//
// A seed operation goes from accept straight to the done state; a draw
// advances the seed, runs the bit-serial remainder unit, waits for its finish
// flag and then loads the output register. A zero span skips the remainder.
// Reset clears both seeds to zero and empties the output register.
// in_ready is high only while the sequencer is idle; a stalled result
// holds in the output register and the next beat may be accepted meanwhile.

module lcg_ranged_random_generator_unit
    import lcgr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     func,
    input  logic signed [WORD_W-1:0] seed_value,
    input  logic        [WORD_W-1:0] system_time,
    input  logic                     use_self,
    input  logic signed [WORD_W-1:0] min_value,
    input  logic signed [WORD_W-1:0] max_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [WORD_W-1:0] value
);

    state_t            state_reg;
    state_t            state_next;
    logic [WORD_W-1:0] main_seed_reg;
    logic [WORD_W-1:0] main_seed_next;
    logic [WORD_W-1:0] self_seed_reg;
    logic [WORD_W-1:0] self_seed_next;
    logic              use_self_reg;
    logic              use_self_next;
    logic [WORD_W-1:0] min_reg;
    logic [WORD_W-1:0] min_next;
    logic [WORD_W-1:0] span_reg;
    logic [WORD_W-1:0] span_next;
    logic [WORD_W-1:0] result_reg;
    logic [WORD_W-1:0] result_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] value_reg;
    logic [WORD_W-1:0] value_next;

    logic              in_fire;
    logic              slot_free;
    logic [WORD_W-1:0] seed_cur;
    logic [WORD_W-1:0] seed_adv;
    logic [WORD_W-1:0] tempered;
    logic              div_start;
    div_status_t       div_status;
    logic [WORD_W-1:0] div_rem;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // Advance the chosen seed and temper it
    assign seed_cur = use_self_reg ? self_seed_reg : main_seed_reg;
    assign seed_adv = WORD_W'(LCG_MUL * seed_cur) + LCG_ADD;
    assign tempered = seed_adv ^ (seed_adv >> TEMPER_SHIFT);

    assign div_start = (state_reg == ST_STEP) && (span_reg != '0);

    lcgr_mod_unit u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (tempered),
        .divisor   (span_reg),
        .status    (div_status),
        .remainder (div_rem)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        main_seed_next = main_seed_reg;
        self_seed_next = self_seed_reg;
        use_self_next  = use_self_reg;
        min_next       = min_reg;
        span_next      = span_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;

        // Drop the output beat once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (func == FUNC_SEED)
                    begin
                        if (seed_value == '0)
                        begin
                            main_seed_next = system_time;
                            self_seed_next = system_time;
                            result_next    = system_time;
                        end
                        else
                        begin
                            main_seed_next = seed_value;
                            result_next    = seed_value;
                        end
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        use_self_next = use_self;
                        min_next      = min_value;
                        span_next     = max_value - min_value + 1'b1;
                        state_next    = ST_STEP;
                    end
                end
            end
            ST_STEP:
            begin
                if (use_self_reg)
                begin
                    self_seed_next = seed_adv;
                end
                else
                begin
                    main_seed_next = seed_adv;
                end
                if (span_reg == '0)
                begin
                    result_next = min_reg;
                    state_next  = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    result_next = min_reg + div_rem;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (slot_free)
                begin
                    value_next     = result_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            main_seed_reg <= '0;
            self_seed_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            main_seed_reg <= main_seed_next;
            self_seed_reg <= self_seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        use_self_reg <= use_self_next;
        min_reg      <= min_next;
        span_reg     <= span_next;
        result_reg   <= result_next;
        value_reg    <= value_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

`ifndef SYNTHESIS
    // Remainder unit only finishes while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIV))
        else $error("remainder finished outside divide state");

    // Seeding with a nonzero value leaves the private seed alone
    a_self_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (func == FUNC_SEED) && (seed_value != '0)) |=> $stable(self_seed_reg))
        else $error("private seed changed by nonzero seeding");

    // A result handed off with a free slot shows up as a valid beat
    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && slot_free) |=> (out_valid && (value == $past(result_reg))))
        else $error("result not loaded into output register");

    // No new request while the remainder unit is running
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> !in_ready)
        else $error("input ready while divide busy");
`endif

endmodule

// ===== tb/lcg_draw_checker.sv =====
`timescale 1ns / 1ps

module lcg_draw_checker
    import lcgr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  func_t                    func,
    input  logic signed [WORD_W-1:0] seed_value,
    input  logic        [WORD_W-1:0] system_time,
    input  logic                     use_self,
    input  logic signed [WORD_W-1:0] min_value,
    input  logic signed [WORD_W-1:0] max_value,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [WORD_W-1:0] value,
    output int                       fail_count,
    output int                       pending,
    output int                       checked
);

    localparam logic [31:0] STEP_MULT  = 32'd214013;
    localparam logic [31:0] STEP_INCR  = 32'd2531011;
    localparam int          MIX_SHIFT  = 15;
    localparam int          MAX_REPORT = 10;

    typedef struct {
        func_t       op;
        logic [31:0] result;
    } expected_t;

    logic [31:0] main_seed_m;
    logic [31:0] self_seed_m;
    expected_t   expected_values[$];
    int          pushed;

    assign pending = pushed - checked;

    // Work out the answer to one request and update the modelled seeds
    function automatic logic [31:0] predict_value(func_t op, logic [31:0] sv, logic [31:0] st,
                                                  logic us, logic [31:0] lo, logic [31:0] hi);
        logic [31:0] s;
        logic [31:0] mixed;
        logic [31:0] span;
        if (op == FUNC_SEED)
        begin
            if (sv == 32'd0)
            begin
                main_seed_m = st;
                self_seed_m = st;
            end
            else
                main_seed_m = sv;
            return main_seed_m;
        end
        if (us)
        begin
            self_seed_m = STEP_MULT * self_seed_m + STEP_INCR;
            s = self_seed_m;
        end
        else
        begin
            main_seed_m = STEP_MULT * main_seed_m + STEP_INCR;
            s = main_seed_m;
        end
        span = hi - lo + 32'd1;
        if (span == 32'd0)
            return lo;
        mixed = s ^ (s >> MIX_SHIFT);
        return lo + (mixed % span);
    endfunction

    // Predict on every request beat, compare on every result beat
    always @(posedge clk or negedge rst_n)
    begin
        expected_t exp_item;
        if (!rst_n)
        begin
            main_seed_m = '0;
            self_seed_m = '0;
            expected_values.delete();
            fail_count = 0;
            pushed     <= 0;
            checked    <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                exp_item.op     = func;
                exp_item.result = predict_value(func, seed_value, system_time, use_self,
                                                min_value, max_value);
                expected_values.push_back(exp_item);
                pushed <= pushed + 1;
            end
            if (out_valid && out_ready)
            begin
                if (expected_values.size() == 0)
                begin
                    if (fail_count < MAX_REPORT)
                        $display("Unexpected result beat: value %h", value);
                    fail_count++;
                end
                else
                begin
                    exp_item = expected_values.pop_front();
                    checked <= checked + 1;
                    if (value !== exp_item.result)
                    begin
                        if (fail_count < MAX_REPORT)
                            $display("Mismatch on %s result: expected %h, got %h",
                                     exp_item.op.name(), exp_item.result, value);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import lcgr_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 40;
    localparam int PHASE_ITEMS = 350;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    func_t                    func = FUNC_SEED;
    logic signed [WORD_W-1:0] seed_value = '0;
    logic        [WORD_W-1:0] system_time = '0;
    logic                     use_self = 1'b0;
    logic signed [WORD_W-1:0] min_value = '0;
    logic signed [WORD_W-1:0] max_value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [WORD_W-1:0] value;

    int fail_count;
    int pending;
    int checked;
    int send_idle_pct = 7;
    int recv_idle_pct = 72;
    int stall_cycles = 0;
    int seed_ops = 0;
    int time_seeds = 0;
    int draws = 0;
    int private_draws = 0;
    int full_range_draws = 0;

    lcg_ranged_random_generator_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .seed_value  (seed_value),
        .system_time (system_time),
        .use_self    (use_self),
        .min_value   (min_value),
        .max_value   (max_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value)
    );

    lcg_draw_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .seed_value  (seed_value),
        .system_time (system_time),
        .use_self    (use_self),
        .min_value   (min_value),
        .max_value   (max_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked)
    );

    initial
    begin
        forever
            #2 clk = ~clk;
    end

    // Randomly back-pressure the result channel
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Abort when neither channel moves a beat for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (rst_n)
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("[lcg_ranged_random_generator_unit] ERROR");
            $finish;
        end
    end

    // Offer one request beat, idling beforehand at random, and hold it until taken
    task automatic issue(input func_t op, input logic [31:0] sv, input logic [31:0] st,
                         input logic us, input logic [31:0] lo, input logic [31:0] hi);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= op;
        seed_value  <= sv;
        system_time <= st;
        use_self    <= us;
        min_value   <= lo;
        max_value   <= hi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (op == FUNC_SEED)
        begin
            seed_ops++;
            if (sv == 32'd0)
                time_seeds++;
        end
        else
        begin
            draws++;
            if (us)
                private_draws++;
            if (hi - lo + 32'd1 == 32'd0)
                full_range_draws++;
        end
    endtask

    task automatic draw(input logic us, input logic [31:0] lo, input logic [31:0] hi);
        issue(FUNC_DRAW, $urandom, $urandom, us, lo, hi);
    endtask

    // Mostly draws over assorted spans, with seeding mixed in
    task automatic random_item();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] sv;
        if ($urandom_range(0, 99) < 22)
        begin
            sv = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
            issue(FUNC_SEED, sv, $urandom, 1'($urandom_range(0, 1)), $urandom, $urandom);
        end
        else
        begin
            lo = $urandom;
            case ($urandom_range(0, 5))
                0: hi = lo + $urandom_range(0, 15);
                1: hi = $urandom;
                2: hi = lo - 32'd1;
                3: hi = lo + (32'd1 << $urandom_range(0, 31)) - 32'd1;
                4: hi = lo - $urandom_range(2, 1000);
                default:
                begin
                    lo = $urandom_range(0, 200) - 100;
                    hi = lo + $urandom_range(0, 300);
                end
            endcase
            draw(1'($urandom_range(0, 1)), lo, hi);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: draws from the reset seeds, then seeding and range corners
        draw(1'b0, 32'd0, 32'd9);
        draw(1'b1, 32'd0, 32'd9);
        issue(FUNC_SEED, 32'h1234_5678, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        draw(1'b1, 32'd0, 32'd1000);
        draw(1'b0, 32'd0, 32'd1000);
        issue(FUNC_SEED, 32'd0, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0);
        draw(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
        draw(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        draw(1'b0, 32'd5, 32'd4);
        draw(1'b1, 32'd0, 32'hFFFF_FFFF);
        draw(1'b0, 32'd100, -32'sd100);
        draw(1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
        draw(1'b0, 32'd42, 32'd42);
        draw(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        draw(1'b0, 32'h8000_0000, 32'h8000_0000);
        draw(1'b1, 32'd0, 32'h7FFF_FFFF);
        draw(1'b0, 32'h8000_0000, 32'hFFFF_FFFF);
        issue(FUNC_SEED, 32'h8000_0000, 32'h0, 1'b1, 32'hFFFF_FFFF, 32'h0);
        issue(FUNC_SEED, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 32'h0);
        issue(FUNC_SEED, 32'd1, 32'h5555_AAAA, 1'b1, 32'h0, 32'h0);
        issue(FUNC_SEED, 32'd0, 32'd0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
        draw(1'b0, -32'sd3, 32'd3);
        draw(1'b1, -32'sd3, 32'd3);

        // Sender idles lightly, receiver heavily
        repeat (PHASE_ITEMS - 23) random_item();

        // Sender idles heavily, receiver lightly
        send_idle_pct = 72;
        recv_idle_pct = 7;
        repeat (PHASE_ITEMS) random_item();

        // Full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (PHASE_ITEMS) random_item();

        // Drop valid and drain the outstanding results
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Checked %0d results: %0d seed operations (%0d from system time), %0d draws",
                 checked, seed_ops, time_seeds, draws);
        $display("Draws: %0d from the private seed, %0d over the full 32-bit range",
                 private_draws, full_range_draws);
        if (fail_count == 0 && pending == 0)
            $display("[lcg_ranged_random_generator_unit] OK");
        else
            $display("[lcg_ranged_random_generator_unit] ERROR");
        $finish;
    end

endmodule
